@@ src/modular_polynomial_evaluator_unit_macros.svh @@
// Assertion macros used by the evaluator checker.
`ifndef MODULAR_POLYNOMIAL_EVALUATOR_UNIT_MACROS_SVH
`define MODULAR_POLYNOMIAL_EVALUATOR_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define MPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define MPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define MPE_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/mpe_pkg.sv @@
// Shared types and constants of the modular polynomial evaluator.
package mpe_pkg;

  localparam int DATA_W      = 64;  // coefficient, point and result width
  localparam int BIT_W       = 6;   // counts DATA_W bits, DATA_W == 2**BIT_W
  localparam int IDX_W       = 6;   // coefficient index field
  localparam int TC_W        = 7;   // term count register
  localparam int S_TDATA_W   = 72;  // coeff_index + operand, padded to bytes
  localparam int M_TDATA_W   = 64;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 64;

  localparam logic [APB_ADDR_W-1:0] ADDR_MODULUS    = 4'h0;
  localparam logic [APB_ADDR_W-1:0] ADDR_TERM_COUNT = 4'h8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_FETCH  = 5'b00010,
    ST_LAUNCH = 5'b00100,
    ST_RUN    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  typedef struct packed {
    logic start;  // load operands and begin one Horner term
    logic wrap;   // modulus register is zero: work modulo 2**64
  } step_ctrl_t;

  typedef struct packed {
    logic done;   // one-cycle pulse, result valid
    logic zero;   // result equals zero
  } step_stat_t;

endpackage

@@ src/mpe_hstep.sv @@
// Bit-serial Horner term: result = (acc * x + coef) mod M, one bit of x and coef per cycle.
module mpe_hstep (
  input  logic                       clk,
  input  logic                       rst,
  input  mpe_pkg::step_ctrl_t        ctrl,
  input  logic [mpe_pkg::DATA_W-1:0] modulus,
  input  logic [mpe_pkg::DATA_W-1:0] acc,
  input  logic [mpe_pkg::DATA_W-1:0] x,
  input  logic [mpe_pkg::DATA_W-1:0] coef,
  output mpe_pkg::step_stat_t        stat,
  output logic [mpe_pkg::DATA_W-1:0] result
);

  localparam int DW = mpe_pkg::DATA_W;
  // DATA_W is a power of two, so the last bit index is all ones
  localparam logic [mpe_pkg::BIT_W-1:0] LAST_BIT = '1;

  logic                      busy;
  logic                      done;
  logic [mpe_pkg::BIT_W-1:0] cnt;
  logic [DW-1:0]             r;
  logic [DW-1:0]             xs;
  logic [DW-1:0]             cs;
  logic [DW-1:0]             a;
  logic [DW:0]               mm;

  logic [DW-1:0]             addend;
  logic [DW+1:0]             sum;
  logic [DW+2:0]             d1;
  logic [DW+2:0]             d2;
  logic [DW-1:0]             r_next;
  logic                      last;

  // 2r + coef bit + x bit * a stays below 3M: pick among sum, sum - M, sum - 2M
  always_comb begin
    addend = xs[DW-1] ? a : '0;
    sum    = {1'b0, r, 1'b0} + (DW+2)'(cs[DW-1]) + {2'b00, addend};
    d1     = {1'b0, sum} - {2'b00, mm};
    d2     = {1'b0, sum} - {1'b0, mm, 1'b0};
    if (!d2[DW+2]) begin
      r_next = d2[DW-1:0];
    end else if (!d1[DW+2]) begin
      r_next = d1[DW-1:0];
    end else begin
      r_next = sum[DW-1:0];
    end
  end

  assign last      = busy && (cnt == LAST_BIT);
  assign result    = r;
  assign stat.done = done;
  assign stat.zero = (r == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= last;
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      r   <= '0;
      cnt <= '0;
      xs  <= x;
      cs  <= coef;
      a   <= acc;
      mm  <= {ctrl.wrap, modulus};
    end else if (busy) begin
      r   <= r_next;
      cnt <= cnt + 1'b1;
      // advance both operands, most significant bit first
      xs  <= {xs[DW-2:0], 1'b0};
      cs  <= {cs[DW-2:0], 1'b0};
    end
  end

endmodule

@@ src/modular_polynomial_evaluator_unit.sv @@
// Top level: coefficient memory, Horner sequencer, config registers and output register.
//
//  channel | handshake               | contents
//  --------+-------------------------+--------------------------------------------------
//  s_*     | tvalid/tready           | tuser: command; tdata: coeff_index, operand
//  m_*     | tvalid/tready           | tuser: is_root; tdata: value
//  apb     | psel/penable/pwrite     | 0x0 modulus (64b), 0x8 term_count (7b)
//
// A load word produces no result. An evaluate word runs n Horner terms, n being the
// term count capped at MAX_TERMS: per coefficient one memory read, a launch state and
// the bit-serial multiply-accumulate unit, which handles one bit per cycle.
// Reset sets the modulus to 1 and clears term_count, the state and the output valid; coefficients are not cleared.
// A pending result waits in the output register while the next word is accepted.
module modular_polynomial_evaluator_unit #(
  parameter int MAX_TERMS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mpe_pkg::S_TDATA_W-1:0]  s_tdata,   // [5:0] coeff_index, [69:6] operand
  input  logic                           s_tuser,   // [0] command
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mpe_pkg::M_TDATA_W-1:0]  m_tdata,   // [63:0] value
  output logic                           m_tuser,   // [0] is_root
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mpe_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mpe_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mpe_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int DW = mpe_pkg::DATA_W;
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);

  logic [DW-1:0]               modulus;
  logic [mpe_pkg::TC_W-1:0]    term_count;
  logic                        cfg_write;

  mpe_pkg::state_t             state;
  mpe_pkg::state_t             state_next;

  logic [mpe_pkg::IDX_W-1:0]   in_index;
  logic [DW-1:0]               in_operand;
  logic                        in_accept;
  logic                        in_load;
  logic                        in_eval;
  logic                        in_range;
  logic [CW-1:0]               n_eff;
  logic                        out_free;

  logic [DW-1:0]               x_reg;
  logic [DW-1:0]               acc;
  logic                        acc_zero;
  logic [CW-1:0]               left;
  logic [AW-1:0]               rd_addr;
  logic [DW-1:0]               mem [MAX_TERMS];
  logic [DW-1:0]               mem_q;

  mpe_pkg::step_ctrl_t         step_ctrl;
  mpe_pkg::step_stat_t         step_stat;
  logic [DW-1:0]               step_result;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus    <= 64'd1;
      term_count <= '0;
    end else if (cfg_write) begin
      unique case (paddr)
        mpe_pkg::ADDR_MODULUS:    modulus    <= pwdata[DW-1:0];
        mpe_pkg::ADDR_TERM_COUNT: term_count <= pwdata[mpe_pkg::TC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      mpe_pkg::ADDR_MODULUS:    prdata = modulus;
      mpe_pkg::ADDR_TERM_COUNT: prdata = {{(mpe_pkg::APB_DATA_W - mpe_pkg::TC_W){1'b0}},
                                          term_count};
      default:                  prdata = '0;
    endcase
  end

  // input word
  assign in_index   = s_tdata[mpe_pkg::IDX_W-1:0];
  assign in_operand = s_tdata[mpe_pkg::IDX_W +: DW];
  assign s_tready   = (state == mpe_pkg::ST_IDLE);
  assign in_accept  = s_tvalid && s_tready;
  assign in_load    = in_accept && (s_tuser == mpe_pkg::CMD_LOAD);
  assign in_eval    = in_accept && (s_tuser == mpe_pkg::CMD_EVAL);
  assign in_range   = (int'(in_index) < MAX_TERMS);
  assign n_eff      = (int'(term_count) > MAX_TERMS) ? CW'(MAX_TERMS) : CW'(term_count);
  assign out_free   = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      mpe_pkg::ST_IDLE: begin
        if (in_eval) begin
          state_next = (n_eff == '0) ? mpe_pkg::ST_DONE : mpe_pkg::ST_FETCH;
        end
      end
      mpe_pkg::ST_FETCH:  state_next = mpe_pkg::ST_LAUNCH;
      mpe_pkg::ST_LAUNCH: state_next = mpe_pkg::ST_RUN;
      mpe_pkg::ST_RUN: begin
        if (step_stat.done) begin
          state_next = (left == CW'(1)) ? mpe_pkg::ST_DONE : mpe_pkg::ST_FETCH;
        end
      end
      mpe_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = mpe_pkg::ST_IDLE;
        end
      end
      default: state_next = mpe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Horner accumulator, highest coefficient first
  always_ff @(posedge clk) begin
    if (in_eval) begin
      x_reg    <= in_operand;
      acc      <= '0;
      acc_zero <= 1'b1;
      left     <= n_eff;
      rd_addr  <= AW'(n_eff - CW'(1));
    end else if ((state == mpe_pkg::ST_RUN) && step_stat.done) begin
      acc      <= step_result;
      acc_zero <= step_stat.zero;
      left     <= left - CW'(1);
      rd_addr  <= rd_addr - AW'(1);
    end
  end

  // coefficient memory: writes only while idle, registered read at rd_addr in every state
  always_ff @(posedge clk) begin
    if (in_load && in_range) begin
      mem[AW'(in_index)] <= in_operand;
    end
    mem_q <= mem[rd_addr];
  end

  assign step_ctrl.start = (state == mpe_pkg::ST_LAUNCH);
  assign step_ctrl.wrap  = (modulus == '0);

  mpe_hstep u_step (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (step_ctrl),
    .modulus (modulus),
    .acc     (acc),
    .x       (x_reg),
    .coef    (mem_q),
    .stat    (step_stat),
    .result  (step_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == mpe_pkg::ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == mpe_pkg::ST_DONE) && out_free) begin
      m_tdata <= acc;
      m_tuser <= acc_zero;
    end
  end

endmodule

@@ src/mpe_checker.sv @@
// Port-level checks of the evaluator, bound to the top level.
`include "modular_polynomial_evaluator_unit_macros.svh"

module mpe_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mpe_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tuser
);

  `MPE_ASSERT_ALWAYS_NEXT(a_reset_drops_output, rst, !m_tvalid, "output valid after reset")

  `MPE_ASSERT_NEXT(a_load_no_result, s_tvalid && s_tready && (s_tuser == mpe_pkg::CMD_LOAD) && !m_tvalid, !m_tvalid, "load word produced a result")

  `MPE_ASSERT_NEXT(a_eval_busy, s_tvalid && s_tready && (s_tuser == mpe_pkg::CMD_EVAL), !s_tready, "input ready right after an evaluate word")

  `MPE_ASSERT_NOW(a_result_frees_input, $rose(m_tvalid), s_tready, "input not ready when a result appears")

  `MPE_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result word changed")

endmodule

bind modular_polynomial_evaluator_unit mpe_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
